// File: design/ref_alt_base_caller_top_defines.svh
// assertion macros for the reference and alternative base caller
`ifndef REF_ALT_BASE_CALLER_TOP_DEFINES_SVH
`define REF_ALT_BASE_CALLER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// property checked on every rising clock edge outside reset
`define RABC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("rabc assertion failed");
// condition that must never be seen outside reset
`define RABC_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("rabc forbidden condition seen");
`else
`define RABC_ASSERT(lbl, prop)
`define RABC_NEVER(lbl, cond)
`endif

`endif

// File: design/rabc_pkg.sv
// types, constants and helper functions for the base caller
`default_nettype none

package rabc_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int CHAR_WIDTH  = 8;
	localparam int NUM_BASES   = 4;

	typedef logic [COUNT_WIDTH-1:0]                  count_t;
	typedef logic [NUM_BASES-1:0][COUNT_WIDTH-1:0]   cnt_vec_t;
	typedef logic [CHAR_WIDTH-1:0]                   char_t;
	typedef logic [1:0]                              idx_t;
	typedef logic [NUM_BASES-1:0][NUM_BASES-1:0]     lt_mat_t;

	localparam char_t CHAR_A = 8'h41;
	localparam char_t CHAR_C = 8'h43;
	localparam char_t CHAR_G = 8'h47;
	localparam char_t CHAR_T = 8'h54;
	localparam char_t CHAR_N = 8'h4E;
	localparam char_t CHAR_LOWER_A = 8'h61;
	localparam char_t CHAR_LOWER_Z = 8'h7A;
	localparam char_t CASE_OFFSET  = 8'h20;

	localparam idx_t IDX_A = 2'd0;
	localparam idx_t IDX_C = 2'd1;
	localparam idx_t IDX_G = 2'd2;
	localparam idx_t IDX_T = 2'd3;

	// one request as held in the input stage
	typedef struct packed {
		cnt_vec_t cnt;
		char_t    ref_in;
		char_t    alt_in;
		logic     force_req;
	} req_t;

	typedef struct packed {
		char_t ref_out;
		char_t alt_out;
	} resp_t;

	// pairwise compare results: lt[i][j] is count i below count j
	typedef struct packed {
		lt_mat_t              lt;
		logic [NUM_BASES-1:0] nz;
	} cmp_t;

	function automatic char_t upper8(input char_t c);
		if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
			return c - CASE_OFFSET;
		end
		return c;
	endfunction

	function automatic logic is_acgt(input char_t c);
		return (c == CHAR_A) || (c == CHAR_C) || (c == CHAR_G) || (c == CHAR_T);
	endfunction

	function automatic char_t base_char(input idx_t i);
		char_t c;
		unique case (i)
			IDX_A: c = CHAR_A;
			IDX_C: c = CHAR_C;
			IDX_G: c = CHAR_G;
			IDX_T: c = CHAR_T;
			default: c = CHAR_N;
		endcase
		return c;
	endfunction

	// only meaningful for an upper-case valid base
	function automatic idx_t base_idx(input char_t c);
		idx_t i;
		unique case (c)
			CHAR_A: i = IDX_A;
			CHAR_C: i = IDX_C;
			CHAR_G: i = IDX_G;
			CHAR_T: i = IDX_T;
			default: i = IDX_A;
		endcase
		return i;
	endfunction

endpackage

`default_nettype wire

// File: design/rabc_if.sv
// request and result channel interfaces of the base caller
`default_nettype none

interface rabc_in_if;
	logic                  valid;
	logic                  ready;
	logic [31:0]           count_a;
	logic [31:0]           count_c;
	logic [31:0]           count_g;
	logic [31:0]           count_t;
	logic [7:0]            ref_in;
	logic [7:0]            alt_in;
	logic                  force_req;

	modport source (
		output valid, count_a, count_c, count_g, count_t, ref_in, alt_in, force_req,
		input  ready
	);
	modport sink (
		input  valid, count_a, count_c, count_g, count_t, ref_in, alt_in, force_req,
		output ready
	);
endinterface

interface rabc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] ref_out;
	logic [7:0] alt_out;

	modport source (
		output valid, ref_out, alt_out,
		input  ready
	);
	modport sink (
		input  valid, ref_out, alt_out,
		output ready
	);
endinterface

`default_nettype wire

// File: design/ref_alt_base_caller_top.sv
// Reference and alternative base caller. Each request carries the A, C, G and T
// counts of one position plus a given reference and alternative character and a
// force flag; the result gives the called reference and alternative characters
// ('N' when no base can be called). One request is taken every cycle unless the
// input is blocked; it passes one input register and one result register,
// with all comparators and both ranking networks in the single logic stage
// between them. A waiting result blocks the input only once the input register
// is full as well; back-pressure holds the result register and, if full, the input one.
`default_nettype none
`include "ref_alt_base_caller_top_defines.svh"

module ref_alt_base_caller_top (
	input  wire logic   clk,
	input  wire logic   arst_n,
	rabc_in_if.sink     in_ch,
	rabc_out_if.source  out_ch
);

	rabc_pkg::req_t  req_in;
	rabc_pkg::req_t  req_s1;
	rabc_pkg::cmp_t  cmp;
	rabc_pkg::resp_t resp;
	rabc_pkg::resp_t resp_s2;
	logic vld_s1;
	logic vld_s2;
	logic adv_s2;
	logic rdy_s1;

	always_comb begin
		req_in.cnt[rabc_pkg::IDX_A] = rabc_pkg::count_t'(in_ch.count_a);
		req_in.cnt[rabc_pkg::IDX_C] = rabc_pkg::count_t'(in_ch.count_c);
		req_in.cnt[rabc_pkg::IDX_G] = rabc_pkg::count_t'(in_ch.count_g);
		req_in.cnt[rabc_pkg::IDX_T] = rabc_pkg::count_t'(in_ch.count_t);
		req_in.ref_in    = in_ch.ref_in;
		req_in.alt_in    = in_ch.alt_in;
		req_in.force_req = in_ch.force_req;
	end

	assign adv_s2      = !vld_s2 || out_ch.ready;
	assign rdy_s1      = !vld_s1 || adv_s2;
	assign in_ch.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_ch.valid) begin
			req_s1 <= req_in;
		end
	end

	rabc_cmp u_cmp (
		.cnt (req_s1.cnt),
		.res (cmp)
	);

	rabc_call u_call (
		.req  (req_s1),
		.cmp  (cmp),
		.resp (resp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			resp_s2 <= resp;
		end
	end

	assign out_ch.valid   = vld_s2;
	assign out_ch.ref_out = resp_s2.ref_out;
	assign out_ch.alt_out = resp_s2.alt_out;

	// an accepted request always lands in the input stage
	`RABC_ASSERT(a_req_lands, in_ch.valid && in_ch.ready |=> vld_s1)
	// the input stage drains whenever the result register is empty
	`RABC_ASSERT(a_s1_drains, vld_s1 && !vld_s2 |=> vld_s2)
	// a blocked input stage keeps its request
	`RABC_ASSERT(a_s1_holds, vld_s1 && vld_s2 && !out_ch.ready |=> $stable(req_s1))

endmodule

`default_nettype wire

// File: design/rabc_cmp.sv
// pairwise count comparators and zero detectors
`default_nettype none

module rabc_cmp (
	input  rabc_pkg::cnt_vec_t cnt,
	output rabc_pkg::cmp_t     res
);

	always_comb begin
		for (int i = 0; i < rabc_pkg::NUM_BASES; i++) begin
			res.nz[i] = (cnt[i] != '0);
			for (int j = 0; j < rabc_pkg::NUM_BASES; j++) begin
				res.lt[i][j] = (cnt[i] < cnt[j]);
			end
		end
	end

endmodule

`default_nettype wire

// File: design/rabc_call.sv
// ranking networks on base indices and the final character selection
`default_nettype none

module rabc_call (
	input  rabc_pkg::req_t  req,
	input  rabc_pkg::cmp_t  cmp,
	output rabc_pkg::resp_t resp
);

	// compare-exchange on two slots: returns {first, second}
	function automatic logic [3:0] cx(
		input rabc_pkg::lt_mat_t lt,
		input rabc_pkg::idx_t    a,
		input rabc_pkg::idx_t    b
	);
		return lt[a][b] ? {b, a} : {a, b};
	endfunction

	rabc_pkg::idx_t rs [4];
	rabc_pkg::idx_t as [4];
	rabc_pkg::char_t ref_up;
	rabc_pkg::char_t alt_up;
	rabc_pkg::char_t ref_call;
	rabc_pkg::char_t alt_call;
	rabc_pkg::idx_t  ref_idx;
	logic ref_keep;
	logic alt_keep;
	logic ref_ok;

	// reference: only the winner of slot 0 matters
	always_comb begin
		rs[0] = rabc_pkg::IDX_A;
		rs[1] = rabc_pkg::IDX_C;
		rs[2] = rabc_pkg::IDX_G;
		rs[3] = rabc_pkg::IDX_T;
		{rs[0], rs[1]} = cx(cmp.lt, rs[0], rs[1]);
		{rs[2], rs[3]} = cx(cmp.lt, rs[2], rs[3]);
		{rs[0], rs[2]} = cx(cmp.lt, rs[0], rs[2]);
		{rs[1], rs[3]} = cx(cmp.lt, rs[1], rs[3]);
		{rs[1], rs[2]} = cx(cmp.lt, rs[1], rs[2]);
	end

	always_comb begin
		ref_up   = rabc_pkg::upper8(req.ref_in);
		ref_keep = !req.force_req && rabc_pkg::is_acgt(ref_up);
		ref_ok   = ref_keep || cmp.nz[rs[0]];
		ref_idx  = ref_keep ? rabc_pkg::base_idx(ref_up) : rs[0];
		if (ref_keep) begin
			ref_call = req.ref_in;
		end else if (cmp.nz[rs[0]]) begin
			ref_call = rabc_pkg::base_char(rs[0]);
		end else begin
			ref_call = rabc_pkg::CHAR_N;
		end
	end

	// alternative: reference in slot 0, remaining bases in ACGT order
	always_comb begin
		as[0] = ref_idx;
		as[1] = (ref_idx == rabc_pkg::IDX_A) ? rabc_pkg::IDX_C : rabc_pkg::IDX_A;
		as[2] = (ref_idx == rabc_pkg::IDX_A || ref_idx == rabc_pkg::IDX_C) ?
			rabc_pkg::IDX_G : rabc_pkg::IDX_C;
		as[3] = (ref_idx == rabc_pkg::IDX_T) ? rabc_pkg::IDX_G : rabc_pkg::IDX_T;
		{as[1], as[2]} = cx(cmp.lt, as[1], as[2]);
		{as[1], as[3]} = cx(cmp.lt, as[1], as[3]);
		{as[2], as[3]} = cx(cmp.lt, as[2], as[3]);
	end

	always_comb begin
		alt_up   = rabc_pkg::upper8(req.alt_in);
		alt_keep = !req.force_req && rabc_pkg::is_acgt(alt_up);
		if (alt_keep) begin
			alt_call = req.alt_in;
		end else if (ref_ok && cmp.nz[as[1]]) begin
			alt_call = rabc_pkg::base_char(as[1]);
		end else begin
			alt_call = rabc_pkg::CHAR_N;
		end
	end

	assign resp = {ref_call, alt_call};

endmodule

`default_nettype wire

// File: test/testbench.sv
// testbench for the reference and alternative base caller, checked against a local predictor
`default_nettype none

module testbench;

	localparam int              CYCLE_LIMIT   = 200000;
	localparam int              RANDOM_ITEMS  = 480;
	localparam int              DRAIN_CYCLES  = 8;
	localparam int              LONG_HOLD     = 60;
	localparam rabc_pkg::count_t CNT_MAX      = '1;
	localparam rabc_pkg::char_t CH_A          = rabc_pkg::CHAR_A;
	localparam rabc_pkg::char_t CH_C          = rabc_pkg::CHAR_C;
	localparam rabc_pkg::char_t CH_G          = rabc_pkg::CHAR_G;
	localparam rabc_pkg::char_t CH_T          = rabc_pkg::CHAR_T;
	localparam rabc_pkg::char_t CH_N          = rabc_pkg::CHAR_N;
	localparam rabc_pkg::char_t BASE_NAME [4] = '{CH_A, CH_C, CH_G, CH_T};

	typedef struct packed {
		rabc_pkg::count_t count_a;
		rabc_pkg::count_t count_c;
		rabc_pkg::count_t count_g;
		rabc_pkg::count_t count_t;
		rabc_pkg::char_t  ref_in;
		rabc_pkg::char_t  alt_in;
		logic             force_req;
	} call_req_t;

	typedef struct {
		call_req_t       req;
		bit              typed;
		rabc_pkg::resp_t want;
	} vector_t;

	typedef struct packed {
		rabc_pkg::char_t  base;
		rabc_pkg::count_t cnt;
	} slot_t;
	typedef slot_t [3:0] slots_t;

	logic clk;
	logic arst_n;
	int   cycle_count;
	int   mismatches;
	int   phase;

	rabc_pkg::resp_t expected_calls[$];
	vector_t         directed[$];

	rabc_in_if  in_ch();
	rabc_out_if out_ch();

	ref_alt_base_caller_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic rabc_pkg::char_t fold_case(input rabc_pkg::char_t c);
		return (c >= rabc_pkg::CHAR_LOWER_A && c <= rabc_pkg::CHAR_LOWER_Z) ?
			(c & ~rabc_pkg::CASE_OFFSET) : c;
	endfunction

	function automatic bit is_nucleotide(input rabc_pkg::char_t c);
		foreach (BASE_NAME[i]) begin
			if (c == BASE_NAME[i]) return 1'b1;
		end
		return 1'b0;
	endfunction

	// ties are never exchanged, so the earlier slot wins
	function automatic slots_t exchange_if_below(input slots_t s, input int i, input int j);
		slot_t t;
		if (s[i].cnt < s[j].cnt) begin
			t = s[i];
			s[i] = s[j];
			s[j] = t;
		end
		return s;
	endfunction

	function automatic rabc_pkg::resp_t call_bases(input call_req_t r);
		rabc_pkg::count_t cnt [4];
		slots_t           s;
		rabc_pkg::char_t  up;
		int               k;
		rabc_pkg::resp_t  res;
		cnt[0] = r.count_a;
		cnt[1] = r.count_c;
		cnt[2] = r.count_g;
		cnt[3] = r.count_t;

		if (!r.force_req && is_nucleotide(fold_case(r.ref_in))) begin
			res.ref_out = r.ref_in;
		end else begin
			for (int i = 0; i < 4; i++) s[i] = '{BASE_NAME[i], cnt[i]};
			s = exchange_if_below(s, 0, 1);
			s = exchange_if_below(s, 2, 3);
			s = exchange_if_below(s, 0, 2);
			s = exchange_if_below(s, 1, 3);
			s = exchange_if_below(s, 1, 2);
			res.ref_out = (s[0].cnt != 0) ? s[0].base : CH_N;
		end

		if (!r.force_req && is_nucleotide(fold_case(r.alt_in))) begin
			res.alt_out = r.alt_in;
		end else begin
			res.alt_out = CH_N;
			up = fold_case(res.ref_out);
			if (is_nucleotide(up)) begin
				// reference base first, the rest in acgt order
				k = 1;
				for (int i = 0; i < 4; i++) begin
					if (BASE_NAME[i] == up) begin
						s[0] = '{BASE_NAME[i], cnt[i]};
					end else begin
						s[k] = '{BASE_NAME[i], cnt[i]};
						k++;
					end
				end
				s = exchange_if_below(s, 1, 2);
				s = exchange_if_below(s, 1, 3);
				s = exchange_if_below(s, 2, 3);
				if (s[1].cnt != 0) res.alt_out = s[1].base;
			end
		end
		return res;
	endfunction

	function automatic rabc_pkg::count_t random_count();
		case ($urandom_range(3))
			0: return '0;
			1: return rabc_pkg::count_t'($urandom_range(3));
			2: return rabc_pkg::count_t'($urandom);
			default: return CNT_MAX - rabc_pkg::count_t'($urandom_range(2));
		endcase
	endfunction

	function automatic rabc_pkg::char_t random_char();
		case ($urandom_range(3))
			0: return BASE_NAME[$urandom_range(3)];
			1: return BASE_NAME[$urandom_range(3)] | rabc_pkg::CASE_OFFSET;
			2: return CH_N;
			default: return rabc_pkg::char_t'($urandom_range(255));
		endcase
	endfunction

	function automatic int source_idle_pct(input int p);
		return (p == 0) ? 33 : (p == 1) ? 74 : 0;
	endfunction

	function automatic int sink_idle_pct(input int p);
		return (p == 0) ? 74 : (p == 1) ? 33 : 0;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH cycle %0d: %s", cycle_count, msg);
		mismatches++;
	endtask

	// offer one request and record its expected call once it is taken
	task automatic send_request(input call_req_t r, input bit typed,
		input rabc_pkg::resp_t want);
		while ($urandom_range(99) < source_idle_pct(phase)) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.count_a   <= r.count_a;
		in_ch.count_c   <= r.count_c;
		in_ch.count_g   <= r.count_g;
		in_ch.count_t   <= r.count_t;
		in_ch.ref_in    <= r.ref_in;
		in_ch.alt_in    <= r.alt_in;
		in_ch.force_req <= r.force_req;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		expected_calls.push_back(typed ? want : call_bases(r));
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TIMEOUT after %0d cycles", cycle_count);
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		rabc_pkg::resp_t want;
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (expected_calls.size() == 0) begin
				report_mismatch($sformatf("call %h/%h with no request outstanding",
					out_ch.ref_out, out_ch.alt_out));
			end else begin
				want = expected_calls.pop_front();
				if (out_ch.ref_out !== want.ref_out)
					report_mismatch($sformatf("ref_out %h, expected %h",
						out_ch.ref_out, want.ref_out));
				if (out_ch.alt_out !== want.alt_out)
					report_mismatch($sformatf("alt_out %h, expected %h",
						out_ch.alt_out, want.alt_out));
			end
		end
	end

	// result side: random stalls, plus one long hold-off to back the block up
	initial begin
		int hold_left;
		bit held;
		hold_left = 0;
		held = 1'b0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (phase == 2 && !held) begin
				hold_left = LONG_HOLD;
				held = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= sink_idle_pct(phase));
			end
		end
	end

	initial begin
		call_req_t r;
		cycle_count = 0;
		mismatches = 0;
		phase = 0;
		arst_n = 1'b0;
		in_ch.valid     <= 1'b0;
		in_ch.count_a   <= '0;
		in_ch.count_c   <= '0;
		in_ch.count_g   <= '0;
		in_ch.count_t   <= '0;
		in_ch.ref_in    <= '0;
		in_ch.alt_in    <= '0;
		in_ch.force_req <= 1'b0;

		directed = '{
			'{'{32'd0, 32'd0, 32'd0, 32'd0, CH_A, CH_C, 1'b1}, 1'b1, '{CH_N, CH_N}},
			'{'{32'd0, 32'd0, 32'd0, 32'd0, "a", "g", 1'b0}, 1'b1, '{"a", "g"}},
			'{'{32'd0, 32'd0, 32'd0, 32'd0, CH_A, 8'hFF, 1'b0}, 1'b1, '{CH_A, CH_N}},
			'{'{CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX, "x", "x", 1'b1}, 1'b1, '{CH_A, CH_C}},
			'{'{32'd0, 32'd0, 32'd0, CNT_MAX, 8'h00, 8'h00, 1'b0}, 1'b1, '{CH_T, CH_N}},
			'{'{32'd0, 32'd0, 32'd1, 32'd0, CH_N, CH_N, 1'b1}, 1'b1, '{CH_G, CH_N}},
			'{'{32'd5, 32'd9, 32'd2, 32'd7, 8'hC1, 8'hE7, 1'b0}, 1'b0, '0},
			'{'{32'd3, 32'd1, 32'd4, 32'd1, "n", CH_N, 1'b0}, 1'b0, '0},
			'{'{32'd12, 32'd40, 32'd40, 32'd3, 8'h00, 8'hFF, 1'b0}, 1'b0, '0},
			// just outside the lower-case range on both sides
			'{'{32'd7, 32'd6, 32'd5, 32'd8, 8'h7B, 8'h60, 1'b0}, 1'b0, '0},
			'{'{32'd2, 32'd2, 32'd9, 32'd9, "z", "a", 1'b0}, 1'b0, '0},
			'{'{32'd3, 32'd3, 32'd8, 32'd1, CH_T, CH_G, 1'b1}, 1'b0, '0},
			'{'{32'd10, 32'd0, 32'd4, 32'd20, "t", 8'h00, 1'b0}, 1'b0, '0},
			'{'{32'd0, 32'd6, 32'd0, 32'd0, "c", "q", 1'b0}, 1'b0, '0},
			'{'{32'd0, 32'd0, 32'd8, 32'd0, CH_G, "@", 1'b0}, 1'b0, '0},
			'{'{32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'd0, "?", "?", 1'b1}, 1'b0, '0},
			'{'{32'd1, 32'hFFFF_FFFE, CNT_MAX, 32'h5555_5555, "g", "t", 1'b1}, 1'b0, '0},
			'{'{32'd0, 32'd7, 32'd7, 32'd0, CH_A, CH_A, 1'b1}, 1'b0, '0},
			'{'{32'd9, 32'd5, 32'd5, 32'd5, CH_A, "z", 1'b0}, 1'b0, '0},
			'{'{32'd1, 32'd1, 32'd1, 32'd1, 8'h80, 8'h7F, 1'b0}, 1'b0, '0},
			'{'{32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0000, 32'h0000_FFFF, "a", "c", 1'b1},
				1'b0, '0},
			'{'{32'd4, 32'd0, 32'd0, 32'd4, CH_T, 8'h20, 1'b0}, 1'b0, '0}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_request(directed[i].req, directed[i].typed, directed[i].want);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			phase = (n * 3) / RANDOM_ITEMS;
			r.count_a   = random_count();
			r.count_c   = random_count();
			r.count_g   = random_count();
			r.count_t   = random_count();
			r.ref_in    = random_char();
			r.alt_in    = random_char();
			r.force_req = ($urandom_range(9) < 3);
			send_request(r, 1'b0, '0);
		end
		in_ch.valid <= 1'b0;

		while (expected_calls.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

`default_nettype wire
